// File: design/crpm_pkg.sv
// ----------------------------------------------------------------------------
// Cascaded roll controller package
// Shared types, register codes and fixed-point constants for the roll
// controller front end, job queue and PID back end.
// ----------------------------------------------------------------------------
package crpm_pkg;

  // Job queue depth between the stick mapper and the PID sequencer.
  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int GAIN_W  = 16;

  // Register indexes on the configuration port (byte address is 4 * index).
  typedef enum logic [2:0] {
    REG_OUTER_KP = 3'd0,
    REG_OUTER_KI = 3'd1,
    REG_OUTER_KD = 3'd2,
    REG_INNER_KP = 3'd3,
    REG_INNER_KI = 3'd4,
    REG_INNER_KD = 3'd5
  } crpm_reg_t;

  // Gain reset values, signed Q8.8.
  localparam int OUTER_KP_RST = 187;
  localparam int OUTER_KI_RST = 5;
  localparam int OUTER_KD_RST = 0;
  localparam int INNER_KP_RST = 256;
  localparam int INNER_KI_RST = 0;
  localparam int INNER_KD_RST = 0;

  // Roll stick map. Upper window gives (p - 930) * 1500 / (930 - 1245),
  // lower window gives (p - 925) * 1500 / (615 - 925). Both ratios are
  // reduced to lowest terms.
  localparam int ROLL_A_LO  = 930;
  localparam int ROLL_A_HI  = 1300;
  localparam int ROLL_B_LO  = 600;
  localparam int ROLL_B_HI  = 925;
  localparam int ROLL_SPAN  = 1500;
  localparam int ROLL_A_DEN = 1245 - 930;
  localparam int ROLL_B_DEN = 925 - 615;
  localparam int ROLL_A_MUL = ROLL_SPAN / 15;
  localparam int ROLL_A_DIV = ROLL_A_DEN / 15;
  localparam int ROLL_B_MUL = ROLL_SPAN / 10;
  localparam int ROLL_B_DIV = ROLL_B_DEN / 10;

  // Throttle map: (p - 615) * (260 - 126) / (1235 - 615) + 126 in 590..1280.
  localparam int THR_LO   = 590;
  localparam int THR_HI   = 1280;
  localparam int THR_ZERO = 615;
  localparam int THR_BASE = 126;
  localparam int THR_MUL  = (260 - 126) / 2;
  localparam int THR_DIV  = (1235 - 615) / 2;
  localparam int THR_OFF  = 600;
  localparam int THR_MIX  = 160;

  // Reciprocals for the small constant divisions, floor(2^16 / d).
  localparam int RECIP_SHIFT  = 16;
  localparam int ROLL_A_RECIP = (2 ** RECIP_SHIFT) / ROLL_A_DIV;
  localparam int ROLL_B_RECIP = (2 ** RECIP_SHIFT) / ROLL_B_DIV;
  localparam int THR_RECIP    = (2 ** RECIP_SHIFT) / THR_DIV;

  // PID datapath.
  localparam int ACC_W       = 50;
  localparam int MUL_W       = GAIN_W + 32;
  localparam int OUTER_DIV   = 25600;
  localparam int INNER_DIV   = 2560000;
  localparam int OUTER_QBITS = 16;
  localparam int INNER_QBITS = 10;
  localparam longint OUTER_LIMIT = longint'(OUTER_DIV) * (longint'(1) << OUTER_QBITS);
  localparam longint INNER_LIMIT = longint'(INNER_DIV) * (longint'(1) << INNER_QBITS);

  // Loop divisors split into a power of two and an odd part; the odd part
  // is divided by a reciprocal multiply, floor(2^23 / d), and one correction.
  localparam int OUTER_PRE   = 10;
  localparam int INNER_PRE   = 12;
  localparam int OUTER_ODD   = OUTER_DIV >> OUTER_PRE;
  localparam int INNER_ODD   = INNER_DIV >> INNER_PRE;
  localparam int DIV_SHIFT   = 23;
  localparam int OUTER_RECIP = (2 ** DIV_SHIFT) / OUTER_ODD;
  localparam int INNER_RECIP = (2 ** DIV_SHIFT) / INNER_ODD;

  localparam int RATE_MAX  = 65535;
  localparam int RATE_MIN  = -65536;
  localparam int DRIVE_MAX = 1023;
  localparam int MOTOR_MAX = 1023;

  typedef struct packed {
    logic signed [GAIN_W-1:0] outer_kp;
    logic signed [GAIN_W-1:0] outer_ki;
    logic signed [GAIN_W-1:0] outer_kd;
    logic signed [GAIN_W-1:0] inner_kp;
    logic signed [GAIN_W-1:0] inner_ki;
    logic signed [GAIN_W-1:0] inner_kd;
  } crpm_gains_t;

  // One classified control tick handed from the front end to the back end.
  typedef struct packed {
    logic signed [11:0] target;
    logic [8:0]         level;
    logic               motors_on;
    logic signed [15:0] angle;
    logic signed [15:0] rate;
  } crpm_job_t;

endpackage

// File: design/crpm_if.sv
// ----------------------------------------------------------------------------
// Cascaded roll controller channels
// Valid/ready channel interfaces for sensor ticks in and motor commands out.
// ----------------------------------------------------------------------------
interface crpm_in_if;
  logic               valid;
  logic               ready;
  logic [11:0]        roll_pulse;
  logic [11:0]        throttle_pulse;
  logic signed [15:0] roll_angle;
  logic signed [15:0] roll_rate;

  modport source (output valid, roll_pulse, throttle_pulse, roll_angle, roll_rate,
                  input ready);
  modport sink (input valid, roll_pulse, throttle_pulse, roll_angle, roll_rate,
                output ready);
endinterface

interface crpm_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         motor_one;
  logic [9:0]         motor_two;
  logic [9:0]         motor_three;
  logic [9:0]         motor_four;
  logic signed [10:0] roll_drive;
  logic [8:0]         throttle_level;

  modport source (output valid, motor_one, motor_two, motor_three, motor_four,
                  roll_drive, throttle_level, input ready);
  modport sink (input valid, motor_one, motor_two, motor_three, motor_four,
                roll_drive, throttle_level, output ready);
endinterface

// File: design/crpm_front.sv
// ----------------------------------------------------------------------------
// Cascaded roll controller front end
// Accepts sensor ticks, maps the stick pulses to a roll target and a
// throttle level in a two-stage pipeline and pushes jobs to the queue.
// ----------------------------------------------------------------------------
module crpm_front (
  input  logic               clk,
  input  logic               rst,
  crpm_in_if.sink            in_ch,
  input  logic               q_full,
  output logic               q_push,
  output crpm_pkg::crpm_job_t q_data
);
  import crpm_pkg::*;

  logic        adv1, adv2;
  logic [11:0] rp, tp;
  logic        roll_hi, roll_lo, thr_win, thr_neg;
  logic [11:0] roll_ofs, thr_mag;
  logic [15:0] roll_x, thr_x;

  // Stage 1: scaled numerators.
  logic               s1_valid;
  logic [15:0]        s1_roll_x, s1_thr_x;
  logic               s1_roll_hi, s1_thr_neg, s1_thr_win, s1_on;
  logic signed [15:0] s1_angle, s1_rate;

  // Stage 2: quotient estimates.
  logic               s2_valid;
  logic [15:0]        s2_roll_x, s2_thr_x;
  logic [11:0]        s2_roll_q;
  logic [7:0]         s2_thr_q;
  logic               s2_roll_hi, s2_thr_neg, s2_thr_win, s2_on;
  logic signed [15:0] s2_angle, s2_rate;

  logic [27:0] roll_prod;
  logic [23:0] thr_prod;
  logic [4:0]  roll_div;
  logic [15:0] roll_rem, thr_rem;
  logic [11:0] roll_q;
  logic [7:0]  thr_q;

  // Pipeline flow: a stage moves when the next one is empty or moving.
  assign q_push      = s2_valid && !q_full;
  assign adv2        = !s2_valid || q_push;
  assign adv1        = !s1_valid || adv2;
  assign in_ch.ready = adv1;

  // Window checks and scaled offsets of both sticks.
  always_comb begin
    rp       = in_ch.roll_pulse;
    tp       = in_ch.throttle_pulse;
    roll_hi  = (rp >= 12'(ROLL_A_LO)) && (rp <= 12'(ROLL_A_HI));
    roll_lo  = (rp >= 12'(ROLL_B_LO)) && (rp <= 12'(ROLL_B_HI));
    roll_ofs = '0;
    roll_x   = '0;
    if (roll_hi) begin
      roll_ofs = rp - 12'(ROLL_A_LO);
      roll_x   = 16'(roll_ofs) * 16'(ROLL_A_MUL);
    end else if (roll_lo) begin
      roll_ofs = 12'(ROLL_B_HI) - rp;
      roll_x   = 16'(roll_ofs) * 16'(ROLL_B_MUL);
    end
    thr_win = (tp >= 12'(THR_LO)) && (tp <= 12'(THR_HI));
    thr_neg = tp < 12'(THR_ZERO);
    thr_mag = thr_neg ? (12'(THR_ZERO) - tp) : (tp - 12'(THR_ZERO));
    thr_x   = thr_win ? (16'(thr_mag) * 16'(THR_MUL)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_roll_x  <= roll_x;
      s1_roll_hi <= roll_hi;
      s1_thr_x   <= thr_x;
      s1_thr_neg <= thr_neg;
      s1_thr_win <= thr_win;
      s1_on      <= tp > 12'(THR_OFF);
      s1_angle   <= in_ch.roll_angle;
      s1_rate    <= in_ch.roll_rate;
    end
  end

  // Reciprocal multiplies give a quotient that is exact or one short.
  always_comb begin
    roll_prod = 28'(s1_roll_x) * 28'(s1_roll_hi ? ROLL_A_RECIP : ROLL_B_RECIP);
    thr_prod  = 24'(s1_thr_x) * 24'(THR_RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_roll_x  <= s1_roll_x;
      s2_roll_hi <= s1_roll_hi;
      s2_roll_q  <= roll_prod[27:RECIP_SHIFT];
      s2_thr_x   <= s1_thr_x;
      s2_thr_q   <= thr_prod[23:RECIP_SHIFT];
      s2_thr_neg <= s1_thr_neg;
      s2_thr_win <= s1_thr_win;
      s2_on      <= s1_on;
      s2_angle   <= s1_angle;
      s2_rate    <= s1_rate;
    end
  end

  // Quotient correction, then sign and offset of both maps.
  always_comb begin
    roll_div = s2_roll_hi ? 5'(ROLL_A_DIV) : 5'(ROLL_B_DIV);
    roll_rem = s2_roll_x - 16'(16'(s2_roll_q) * 16'(roll_div));
    roll_q   = (roll_rem >= 16'(roll_div)) ? (s2_roll_q + 12'd1) : s2_roll_q;
    thr_rem  = s2_thr_x - 16'(16'(s2_thr_q) * 16'(THR_DIV));
    thr_q    = (thr_rem >= 16'(THR_DIV)) ? (s2_thr_q + 8'd1) : s2_thr_q;

    q_data.target    = s2_roll_hi ? (12'd0 - roll_q) : roll_q;
    q_data.level     = '0;
    if (s2_thr_win) begin
      q_data.level = s2_thr_neg ? (9'(THR_BASE) - 9'(thr_q)) : (9'(THR_BASE) + 9'(thr_q));
    end
    q_data.motors_on = s2_on;
    q_data.angle     = s2_angle;
    q_data.rate      = s2_rate;
  end

endmodule

// File: design/crpm_queue.sv
// ----------------------------------------------------------------------------
// Cascaded roll controller job queue
// Short register FIFO that decouples the front end from the PID back end.
// ----------------------------------------------------------------------------
module crpm_queue #(
  parameter int DEPTH = crpm_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  crpm_pkg::crpm_job_t wdata,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output crpm_pkg::crpm_job_t rdata
);
  import crpm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  crpm_job_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign valid = count != '0;
  assign rdata = entries[rd_ptr];

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

// File: design/crpm_back.sv
// ----------------------------------------------------------------------------
// Cascaded roll controller back end
// Sequencer that runs the outer angle PID and the inner rate PID on one
// shared multiplier and one reciprocal-multiply divider, then mixes the motors.
// ----------------------------------------------------------------------------
module crpm_back (
  input  logic                  clk,
  input  logic                  rst,
  input  crpm_pkg::crpm_gains_t gains,
  input  logic                  job_valid,
  input  crpm_pkg::crpm_job_t   job,
  output logic                  job_pop,
  crpm_out_if.source            out_ch
);
  import crpm_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_SUM  = 11'b00000000010,
    S_MP   = 11'b00000000100,
    S_MD   = 11'b00000001000,
    S_M100 = 11'b00000010000,
    S_MI   = 11'b00000100000,
    S_MAG  = 11'b00001000000,
    S_DIV  = 11'b00010000000,
    S_FIX  = 11'b00100000000,
    S_FIN  = 11'b01000000000,
    S_MIX  = 11'b10000000000
  } state_t;

  state_t state, state_next;

  crpm_job_t           job_r;
  logic                inner_loop;
  logic signed [17:0]  err;
  logic signed [31:0]  sum_r;
  logic signed [18:0]  diff_r;
  logic signed [ACC_W-1:0] acc;
  logic                neg_r, sat_r;
  logic [20:0]         div_x;
  logic [9:0]          div_d;
  logic [18:0]         div_recip;
  logic [15:0]         quo;
  logic signed [10:0]  drive_r;

  // Controller state.
  logic signed [31:0]  outer_sum, inner_sum;
  logic signed [16:0]  outer_prev;
  logic signed [17:0]  inner_prev;

  logic signed [31:0]  cur_sum;
  logic signed [17:0]  cur_prev;
  logic signed [32:0]  sum_wide;
  logic signed [31:0]  sum_sat;
  logic signed [18:0]  diff;
  logic signed [GAIN_W-1:0] mul_gain;
  logic signed [31:0]  mul_op;
  logic signed [MUL_W-1:0] mul_prod;
  logic [ACC_W-1:0]    acc_mag;
  logic [38:0]         div_prod;
  logic [20:0]         div_rem;
  logic                div_up;
  logic signed [16:0]  quo_s, res;
  logic signed [11:0]  mix_plus, mix_minus;
  logic                out_valid, out_load;
  logic [9:0]          m_one, m_two;

  function automatic logic [9:0] clamp_motor(input logic signed [11:0] x);
    if (x < 12'sd0) begin
      return '0;
    end else if (x > 12'(MOTOR_MAX)) begin
      return 10'(MOTOR_MAX);
    end
    return x[9:0];
  endfunction

  // Integral sum with saturation and error difference of the current loop.
  always_comb begin
    cur_sum  = inner_loop ? inner_sum : outer_sum;
    cur_prev = inner_loop ? inner_prev : {outer_prev[16], outer_prev};
    sum_wide = {cur_sum[31], cur_sum} + {{15{err[17]}}, err};
    sum_sat  = sum_wide[31:0];
    if (sum_wide[32] != sum_wide[31]) begin
      sum_sat = sum_wide[32] ? 32'sh80000000 : 32'sh7fffffff;
    end
    diff = {err[17], err} - {cur_prev[17], cur_prev};
  end

  // Shared gain multiplier.
  always_comb begin
    case (state)
      S_MP: begin
        mul_gain = inner_loop ? gains.inner_kp : gains.outer_kp;
        mul_op   = {{14{err[17]}}, err};
      end
      S_MD: begin
        mul_gain = inner_loop ? gains.inner_kd : gains.outer_kd;
        mul_op   = {{13{diff_r[18]}}, diff_r};
      end
      default: begin
        mul_gain = inner_loop ? gains.inner_ki : gains.outer_ki;
        mul_op   = sum_r;
      end
    endcase
    mul_prod = mul_gain * mul_op;
  end

  // Magnitude, reciprocal quotient estimate, its correction and the sign.
  always_comb begin
    acc_mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    div_prod = 39'(div_x) * 39'(div_recip);
    div_rem  = div_x - 21'(quo) * 21'(div_d);
    div_up   = div_rem >= 21'(div_d);
    quo_s    = {1'b0, quo};
    res      = neg_r ? (17'sd0 - quo_s) : quo_s;
    if (sat_r) begin
      if (inner_loop) begin
        res = neg_r ? -17'(DRIVE_MAX) : 17'(DRIVE_MAX);
      end else begin
        res = neg_r ? 17'(RATE_MIN) : 17'(RATE_MAX);
      end
    end
  end

  // Motor mixer.
  always_comb begin
    mix_plus  = {3'b000, job_r.level} + {drive_r[10], drive_r};
    mix_minus = {3'b000, job_r.level} - {drive_r[10], drive_r};
    if (!job_r.motors_on) begin
      m_one = '0;
      m_two = '0;
    end else if (job_r.level > 9'(THR_MIX)) begin
      m_one = clamp_motor(mix_plus);
      m_two = clamp_motor(mix_minus);
    end else begin
      m_one = {1'b0, job_r.level};
      m_two = {1'b0, job_r.level};
    end
  end

  assign out_load = !out_valid || out_ch.ready;
  assign job_pop  = (state == S_IDLE) && job_valid;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (job_valid) state_next = S_SUM;
      S_SUM:  state_next = S_MP;
      S_MP:   state_next = S_MD;
      S_MD:   state_next = S_M100;
      S_M100: state_next = S_MI;
      S_MI:   state_next = S_MAG;
      S_MAG: begin
        state_next = (acc_mag >= (inner_loop ? ACC_W'(INNER_LIMIT) : ACC_W'(OUTER_LIMIT)))
                     ? S_FIN : S_DIV;
      end
      S_DIV:  state_next = S_FIX;
      S_FIX:  state_next = S_FIN;
      S_FIN:  state_next = inner_loop ? S_MIX : S_SUM;
      S_MIX:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Loop state: integral sums and previous errors.
  always_ff @(posedge clk) begin
    if (rst) begin
      outer_sum  <= '0;
      outer_prev <= '0;
      inner_sum  <= '0;
      inner_prev <= '0;
    end else if (state == S_SUM) begin
      if (inner_loop) begin
        inner_sum  <= sum_sat;
        inner_prev <= err;
      end else begin
        outer_sum  <= sum_sat;
        outer_prev <= err[16:0];
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (job_valid) begin
          job_r      <= job;
          inner_loop <= 1'b0;
          err        <= {{6{job.target[11]}}, job.target} - {{2{job.angle[15]}}, job.angle};
        end
      end
      S_SUM: begin
        sum_r  <= sum_sat;
        diff_r <= diff;
      end
      S_MP: acc <= {{(ACC_W - MUL_W){mul_prod[MUL_W-1]}}, mul_prod};
      S_MD: acc <= acc + {{(ACC_W - MUL_W){mul_prod[MUL_W-1]}}, mul_prod};
      S_M100: acc <= (acc <<< 6) + (acc <<< 5) + (acc <<< 2);
      S_MI: acc <= acc + {{(ACC_W - MUL_W){mul_prod[MUL_W-1]}}, mul_prod};
      S_MAG: begin
        // Drop the power-of-two part of the divisor; the rest goes to the
        // reciprocal multiply.
        neg_r     <= acc[ACC_W-1];
        sat_r     <= acc_mag >= (inner_loop ? ACC_W'(INNER_LIMIT) : ACC_W'(OUTER_LIMIT));
        div_x     <= inner_loop ? acc_mag[INNER_PRE+20:INNER_PRE]
                                : acc_mag[OUTER_PRE+20:OUTER_PRE];
        div_d     <= inner_loop ? 10'(INNER_ODD) : 10'(OUTER_ODD);
        div_recip <= inner_loop ? 19'(INNER_RECIP) : 19'(OUTER_RECIP);
        quo       <= '0;
      end
      // The estimate is exact or one short.
      S_DIV: quo <= div_prod[DIV_SHIFT+15:DIV_SHIFT];
      S_FIX: begin
        if (div_up) begin
          quo <= quo + 16'd1;
        end
      end
      S_FIN: begin
        if (inner_loop) begin
          drive_r <= res[10:0];
        end else begin
          inner_loop <= 1'b1;
          err        <= {res[16], res} - {{2{job_r.rate[15]}}, job_r.rate};
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_MIX) && out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_MIX) && out_load) begin
      out_ch.motor_one      <= m_one;
      out_ch.motor_two      <= m_two;
      out_ch.motor_three    <= m_one;
      out_ch.motor_four     <= m_two;
      out_ch.roll_drive     <= drive_r;
      out_ch.throttle_level <= job_r.level;
    end
  end

  assign out_ch.valid = out_valid;

`ifndef SYNTHESIS
  // The divider only runs on values whose quotient fits the loop range.
  assert property (@(posedge clk) disable iff (rst) (state == S_DIV) |-> !sat_r)
    else $error("divider running on a saturated numerator");

  // The quotient estimate is always followed by its correction step.
  assert property (@(posedge clk) disable iff (rst)
                   (state == S_DIV) |=> (state == S_FIX))
    else $error("divider estimate not followed by its correction");

  // A new job always starts with the outer loop.
  assert property (@(posedge clk) disable iff (rst)
                   job_pop |=> (state == S_SUM) && !inner_loop)
    else $error("job did not start on the outer loop");

  // Motor pairs on the same side always carry the same command.
  assert property (@(posedge clk) disable iff (rst)
                   out_valid |-> (out_ch.motor_one == out_ch.motor_three) &&
                                 (out_ch.motor_two == out_ch.motor_four))
    else $error("motor pair commands differ");
`endif

endmodule

// File: design/cascaded_roll_pid_motor_mixer_core.sv
// ----------------------------------------------------------------------------
// Cascaded roll PID controller with motor mixer
// Maps stick pulses, runs an outer angle PID feeding an inner rate PID, and
// mixes the roll drive into four motor commands. Gains sit on an APB port.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Transaction contents
//   in_ch     in    roll_pulse, throttle_pulse, roll_angle, roll_rate
//   out_ch    out   motor_one..motor_four, roll_drive, throttle_level
//   APB       in    six signed Q8.8 gains at byte address 4 * index
//
// The front end pipelines the stick maps and queues the job. The back end
// takes a job in S_IDLE, runs each loop through S_SUM, S_MP, S_MD, S_M100,
// S_MI, S_MAG, S_DIV, S_FIX and S_FIN on the shared 16x32 multiplier and the
// two-step reciprocal divide, and mixes in S_MIX. A saturated loop skips its
// divide. Reset is synchronous and clears the loop state and gains to their
// defaults. The front keeps accepting ticks while the queue has room, and the
// back end stalls only while the output register still holds a result.
// ----------------------------------------------------------------------------
module cascaded_roll_pid_motor_mixer_core #(
  parameter int QUEUE_DEPTH = crpm_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  crpm_in_if.sink                      in_ch,
  crpm_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [crpm_pkg::PADDR_W-1:0] paddr,
  input  logic [crpm_pkg::PDATA_W-1:0] pwdata,
  output logic [crpm_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import crpm_pkg::*;

  crpm_gains_t gains;
  logic [2:0]  reg_idx;
  logic        cfg_write;
  logic        q_push, q_full, q_pop, q_valid;
  crpm_job_t   q_wdata, q_rdata;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Gain registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.outer_kp <= GAIN_W'(OUTER_KP_RST);
      gains.outer_ki <= GAIN_W'(OUTER_KI_RST);
      gains.outer_kd <= GAIN_W'(OUTER_KD_RST);
      gains.inner_kp <= GAIN_W'(INNER_KP_RST);
      gains.inner_ki <= GAIN_W'(INNER_KI_RST);
      gains.inner_kd <= GAIN_W'(INNER_KD_RST);
    end else if (cfg_write) begin
      case (reg_idx)
        REG_OUTER_KP: gains.outer_kp <= pwdata[GAIN_W-1:0];
        REG_OUTER_KI: gains.outer_ki <= pwdata[GAIN_W-1:0];
        REG_OUTER_KD: gains.outer_kd <= pwdata[GAIN_W-1:0];
        REG_INNER_KP: gains.inner_kp <= pwdata[GAIN_W-1:0];
        REG_INNER_KI: gains.inner_ki <= pwdata[GAIN_W-1:0];
        REG_INNER_KD: gains.inner_kd <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback, sign extended.
  always_comb begin
    case (reg_idx)
      REG_OUTER_KP: prdata = PDATA_W'(gains.outer_kp);
      REG_OUTER_KI: prdata = PDATA_W'(gains.outer_ki);
      REG_OUTER_KD: prdata = PDATA_W'(gains.outer_kd);
      REG_INNER_KP: prdata = PDATA_W'(gains.inner_kp);
      REG_INNER_KI: prdata = PDATA_W'(gains.inner_ki);
      REG_INNER_KD: prdata = PDATA_W'(gains.inner_kd);
      default:      prdata = '0;
    endcase
  end

  crpm_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  crpm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  crpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .gains     (gains),
    .job_valid (q_valid),
    .job       (q_rdata),
    .job_pop   (q_pop),
    .out_ch    (out_ch)
  );

endmodule

// File: dv/cascaded_roll_pid_motor_mixer_core_tb.sv
// ----------------------------------------------------------------------------
// Cascaded roll PID motor mixer testbench
// Sends control ticks through the valid/ready input channel and checks every
// motor command against an in-bench model of the stick maps, both PID loops
// and the mixer. Gains are set over APB between phases, including the
// extremes, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module cascaded_roll_pid_motor_mixer_core_tb;
  import crpm_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 6;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int REG_COUNT    = 6;
  localparam int PHASES       = 9;
  localparam int PHASE_TICKS  = 150;
  localparam int CORNERS      = 20;
  localparam int MAX_REPORTS  = 10;

  // Thresholds of the mixer.
  localparam int THROTTLE_CUTOFF = 600;
  localparam int MIX_FLOOR       = 160;

  typedef logic signed [15:0] gain_set_t [REG_COUNT];

  typedef struct packed {
    logic [11:0]        roll_pulse;
    logic [11:0]        throttle_pulse;
    logic signed [15:0] roll_angle;
    logic signed [15:0] roll_rate;
  } stick_tick_t;

  typedef struct packed {
    logic [9:0]         motor_one;
    logic [9:0]         motor_two;
    logic [9:0]         motor_three;
    logic [9:0]         motor_four;
    logic signed [10:0] roll_drive;
    logic [8:0]         throttle_level;
  } motor_cmd_t;

  // Predicts the motor command of each accepted tick and checks the results.
  class roll_mixer_scoreboard;
    logic signed [15:0] gain [REG_COUNT];
    int                 angle_sum;
    int                 angle_prev;
    int                 rate_sum;
    int                 rate_prev;
    motor_cmd_t         expected_cmds [$];
    int unsigned        errors;

    function new();
      gain[REG_OUTER_KP] = 16'(OUTER_KP_RST);
      gain[REG_OUTER_KI] = 16'(OUTER_KI_RST);
      gain[REG_OUTER_KD] = 16'(OUTER_KD_RST);
      gain[REG_INNER_KP] = 16'(INNER_KP_RST);
      gain[REG_INNER_KI] = 16'(INNER_KI_RST);
      gain[REG_INNER_KD] = 16'(INNER_KD_RST);
      angle_sum  = 0;
      angle_prev = 0;
      rate_sum   = 0;
      rate_prev  = 0;
      errors     = 0;
    endfunction

    // Only the low 16 bits count; indexes past the last gain are dropped.
    function void set_gain(int unsigned idx, logic [31:0] value);
      if (idx < REG_COUNT) gain[idx] = value[15:0];
    endfunction

    function int unsigned pending();
      return expected_cmds.size();
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // Stick maps; integer division truncates toward zero.
    function int roll_setpoint(int p);
      if (p >= 930 && p <= 1300) return (p - 930) * 1500 / (-315);
      if (p >= 600 && p <= 925) return (p - 925) * 1500 / (-310);
      return 0;
    endfunction

    function int throttle_of(int p);
      if (p >= 590 && p <= 1280) return (p - 615) * 134 / 620 + 126;
      return 0;
    endfunction

    // One PID step: saturating sum, difference, and the scaled numerator.
    function longint loop_numerator(int err, inout int sum, inout int prev,
                                    int kp, int ki, int kd);
      longint s;
      longint d;
      s = clip(longint'(sum) + err, -longint'(2147483647) - 1, 2147483647);
      d = longint'(err) - prev;
      sum  = int'(s);
      prev = err;
      return 100 * longint'(kp) * err + longint'(ki) * s + 100 * longint'(kd) * d;
    endfunction

    function void note_tick(stick_tick_t t);
      int         target;
      int         level;
      int         angle;
      int         rate;
      int         thr;
      longint     numer;
      longint     rate_cmd;
      longint     drive;
      longint     m_plus;
      longint     m_minus;
      motor_cmd_t cmd;
      target = roll_setpoint(t.roll_pulse);
      thr    = t.throttle_pulse;
      level  = throttle_of(thr);
      angle  = t.roll_angle;
      rate   = t.roll_rate;

      // Outer angle loop gives the rate target.
      numer = loop_numerator(target - angle, angle_sum, angle_prev,
                             gain[REG_OUTER_KP], gain[REG_OUTER_KI], gain[REG_OUTER_KD]);
      rate_cmd = clip(numer / 25600, -65536, 65535);

      // Inner rate loop gives the roll drive in motor counts.
      numer = loop_numerator(int'(rate_cmd - rate), rate_sum, rate_prev,
                             gain[REG_INNER_KP], gain[REG_INNER_KI], gain[REG_INNER_KD]);
      drive = clip(numer / 2560000, -1023, 1023);

      // Mixer: motors off, low throttle without drive, or full mix.
      if (thr <= THROTTLE_CUTOFF) begin
        m_plus  = 0;
        m_minus = 0;
      end else if (level <= MIX_FLOOR) begin
        m_plus  = level;
        m_minus = level;
      end else begin
        m_plus  = clip(level + drive, 0, 1023);
        m_minus = clip(level - drive, 0, 1023);
      end

      cmd.motor_one      = m_plus[9:0];
      cmd.motor_two      = m_minus[9:0];
      cmd.motor_three    = m_plus[9:0];
      cmd.motor_four     = m_minus[9:0];
      cmd.roll_drive     = drive[10:0];
      cmd.throttle_level = level[8:0];
      expected_cmds.push_back(cmd);
    endfunction

    function void check_motor_cmd(motor_cmd_t got);
      motor_cmd_t want;
      if (expected_cmds.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected motor command: m=%0d/%0d/%0d/%0d drive=%0d level=%0d",
                   got.motor_one, got.motor_two, got.motor_three, got.motor_four,
                   got.roll_drive, got.throttle_level);
        return;
      end
      want = expected_cmds.pop_front();
      if (got.motor_one !== want.motor_one || got.motor_two !== want.motor_two ||
          got.motor_three !== want.motor_three || got.motor_four !== want.motor_four ||
          got.roll_drive !== want.roll_drive ||
          got.throttle_level !== want.throttle_level) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("motor command mismatch at %0t", $time);
          $display("  expected m=%0d/%0d/%0d/%0d drive=%0d level=%0d",
                   want.motor_one, want.motor_two, want.motor_three, want.motor_four,
                   want.roll_drive, want.throttle_level);
          $display("  actual   m=%0d/%0d/%0d/%0d drive=%0d level=%0d",
                   got.motor_one, got.motor_two, got.motor_three, got.motor_four,
                   got.roll_drive, got.throttle_level);
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  bit                  steady = 1'b0;

  roll_mixer_scoreboard mixer_sb = new();

  crpm_in_if  in_if ();
  crpm_out_if out_if ();

  cascaded_roll_pid_motor_mixer_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Corner ticks: window edges of both sticks, field extremes, both mixer modes.
  int corner_roll [CORNERS] = '{0, 4095, 600, 599, 925, 926, 929, 930, 1245, 1300,
                                1301, 700, 1100, 800, 1000, 650, 2048, 1024, 930, 1262};
  int corner_thr [CORNERS] = '{0, 4095, 600, 601, 589, 590, 614, 615, 772, 777,
                               1280, 1281, 1000, 1200, 1250, 1100, 2048, 1024, 1280, 900};
  int corner_angle [CORNERS] = '{0, 18000, -18000, 0, 100, -100, 250, -250, 0, 3000,
                                 -3000, 0, -18000, 18000, 5000, -5000, 0, -1, 18000, 1234};
  int corner_rate [CORNERS] = '{0, 32767, -32768, 0, -100, 100, 0, 0, 500, -500,
                                0, 0, 32767, -32768, 0, 1000, -1, 1, -32768, 7777};

  function automatic stick_tick_t make_tick(int rp, int tp, int angle, int rate);
    stick_tick_t t;
    t.roll_pulse     = 12'(rp);
    t.throttle_pulse = 12'(tp);
    t.roll_angle     = 16'(angle);
    t.roll_rate      = 16'(rate);
    return t;
  endfunction

  // Mostly sticks near their windows; now and then any pulse width.
  function automatic stick_tick_t random_tick();
    int rp;
    int tp;
    int angle;
    int rate;
    rp = ($urandom_range(0, 9) < 7) ? int'($urandom_range(560, 1340))
                                     : int'($urandom_range(0, 4095));
    tp = ($urandom_range(0, 9) < 7) ? int'($urandom_range(560, 1320))
                                     : int'($urandom_range(0, 4095));
    if ($urandom_range(0, 3) == 0) angle = int'($urandom_range(0, 1000)) - 500;
    else angle = int'($urandom_range(0, 36000)) - 18000;
    if ($urandom_range(0, 3) == 0) rate = int'($urandom_range(0, 4000)) - 2000;
    else rate = int'($urandom_range(0, 65535)) - 32768;
    return make_tick(rp, tp, angle, rate);
  endfunction

  // Gains of a plausible tuning, with the odd negative one.
  function automatic gain_set_t tame_gains();
    gain_set_t g;
    int        top;
    for (int i = 0; i < REG_COUNT; i++) begin
      top  = (i == REG_OUTER_KI || i == REG_INNER_KI) ? 64 : 700;
      g[i] = 16'($urandom_range(0, top));
      if ($urandom_range(0, 7) == 0) g[i] = -g[i];
    end
    return g;
  endfunction

  // Sends one tick after a random idle gap and waits for its transaction.
  task automatic send_tick(input stick_tick_t t);
    int unsigned gap;
    gap = 0;
    while (!steady && $urandom_range(0, 99) < 25) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.roll_pulse     <= t.roll_pulse;
    in_if.throttle_pulse <= t.throttle_pulse;
    in_if.roll_angle     <= t.roll_angle;
    in_if.roll_rate      <= t.roll_rate;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    mixer_sb.note_tick(t);
  endtask

  // One APB write; the caller closes the transfer after the last one.
  task automatic apb_write(input int unsigned idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mixer_sb.set_gain(idx, data);
  endtask

  // Writes all six gains with junk in the upper half of the bus, and
  // optionally pokes the unused addresses past the last gain.
  task automatic program_gains(input gain_set_t g, input bit stray);
    for (int i = 0; i < REG_COUNT; i++) apb_write(i, {16'($urandom), g[i]});
    if (stray) begin
      apb_write(REG_COUNT, $urandom);
      apb_write(REG_COUNT + 1, $urandom);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (mixer_sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, two long hold-offs, and the checks.
  initial begin : motor_sink
    int unsigned taken;
    int unsigned hold;
    taken = 0;
    hold  = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_if.valid && out_if.ready) begin
        mixer_sb.check_motor_cmd({out_if.motor_one, out_if.motor_two, out_if.motor_three,
                                  out_if.motor_four, out_if.roll_drive,
                                  out_if.throttle_level});
        taken++;
        if (taken == 333 || taken == 1001) hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !rst && (steady || $urandom_range(0, 99) >= 25);
      end
    end
  end

  // Stimulus: corner ticks on reset gains, then one random phase per setting.
  initial begin : stimulus
    gain_set_t gains;
    in_if.valid          <= 1'b0;
    in_if.roll_pulse     <= '0;
    in_if.throttle_pulse <= '0;
    in_if.roll_angle     <= '0;
    in_if.roll_rate      <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < CORNERS; i++)
      send_tick(make_tick(corner_roll[i], corner_thr[i], corner_angle[i], corner_rate[i]));
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: foreach (gains[i]) gains[i] = 16'sh7fff;
        2: foreach (gains[i]) gains[i] = 16'sh8000;
        3: foreach (gains[i]) gains[i] = '0;
        5, 7: foreach (gains[i]) gains[i] = 16'($urandom);
        8: begin
          gains[REG_OUTER_KP] = 16'(OUTER_KP_RST);
          gains[REG_OUTER_KI] = 16'(OUTER_KI_RST);
          gains[REG_OUTER_KD] = 16'(OUTER_KD_RST);
          gains[REG_INNER_KP] = 16'(INNER_KP_RST);
          gains[REG_INNER_KI] = 16'(INNER_KI_RST);
          gains[REG_INNER_KD] = 16'(INNER_KD_RST);
        end
        default: gains = tame_gains();
      endcase
      program_gains(gains, ph == 1 || ph == 3);
      // One phase runs with no idling on either side.
      steady = (ph == 4);
      repeat (PHASE_TICKS) send_tick(random_tick());
      wait_drained();
    end
    steady = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mixer_sb.errors == 0 && mixer_sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("Regression FAIL");
    $finish;
  end

endmodule
